### hdl/wfcs_pkg.sv
// Shared types, constants and helper functions of the wall-follow cell stepper.
package wfcs_pkg;

	localparam int SPEED_W = 15;
	localparam int WIDE_W  = 25;

	localparam logic signed [WIDE_W-1:0] SPEED_LIMIT = 25'sd10240;

	localparam logic signed [31:0] CELL_COUNTS  = 32'sd15;
	localparam logic signed [31:0] PIVOT_COUNTS = 32'sd7;
	localparam logic signed [31:0] UTURN_COUNTS = 32'sd14;

	// floor(x / 5) == (x * FIFTH_RECIP) >> FIFTH_SHIFT for every 16-bit x
	localparam logic [15:0] FIFTH_RECIP = 16'd52429;
	localparam int          FIFTH_SHIFT = 18;

	localparam logic [1:0] MAN_FORWARD = 2'd0;
	localparam logic [1:0] MAN_LEFT    = 2'd1;
	localparam logic [1:0] MAN_RIGHT   = 2'd2;
	localparam logic [1:0] MAN_UTURN   = 2'd3;

	localparam logic [1:0] DRV_TRIM    = 2'd0;
	localparam logic [1:0] DRV_FIFTH   = 2'd1;
	localparam logic [1:0] DRV_PIVOT_L = 2'd2;
	localparam logic [1:0] DRV_PIVOT_R = 2'd3;

	localparam logic [2:0] REG_FRONT_THR = 3'd0;
	localparam logic [2:0] REG_LEFT_THR  = 3'd1;
	localparam logic [2:0] REG_RIGHT_THR = 3'd2;
	localparam logic [2:0] REG_LEFT_SET  = 3'd3;
	localparam logic [2:0] REG_RIGHT_SET = 3'd4;
	localparam logic [2:0] REG_LEFT_BASE = 3'd5;
	localparam logic [2:0] REG_RIGHT_BASE = 3'd6;
	localparam logic [2:0] REG_GAIN      = 3'd7;

	typedef struct packed {
		logic [11:0] front_threshold;
		logic [11:0] left_threshold;
		logic [11:0] right_threshold;
		logic [11:0] left_setpoint;
		logic [11:0] right_setpoint;
		logic [13:0] left_base_speed;
		logic [13:0] right_base_speed;
		logic [15:0] steer_gain;
	} cfg_t;

	function automatic logic [1:0] maneuver_of(input logic [2:0] pattern);
		logic [1:0] m;
		case (pattern)
			3'd1, 3'd4, 3'd5: m = MAN_LEFT;
			3'd3:             m = MAN_RIGHT;
			3'd7:             m = MAN_UTURN;
			default:          m = MAN_FORWARD;
		endcase
		return m;
	endfunction

	function automatic logic signed [SPEED_W-1:0] clamp_speed(
		input logic signed [WIDE_W-1:0] v);
		logic signed [SPEED_W-1:0] r;
		if (v > SPEED_LIMIT) begin
			r = SPEED_LIMIT[SPEED_W-1:0];
		end else if (v < -SPEED_LIMIT) begin
			r = -(SPEED_LIMIT[SPEED_W-1:0]);
		end else begin
			r = v[SPEED_W-1:0];
		end
		return r;
	endfunction

endpackage

### hdl/wfcs_tick_if.sv
// Handshake channel carrying one control tick of sensor readings.
interface wfcs_tick_if;
	logic               valid;
	logic               ready;
	logic        [11:0] left_distance;
	logic        [11:0] front_distance;
	logic        [11:0] right_distance;
	logic signed [31:0] wheel_position;

	modport source (output valid, left_distance, front_distance, right_distance,
		wheel_position, input ready);
	modport sink (input valid, left_distance, front_distance, right_distance,
		wheel_position, output ready);
endinterface

### hdl/wfcs_cmd_if.sv
// Handshake channel carrying one wheel command result.
interface wfcs_cmd_if;
	logic               valid;
	logic               ready;
	logic signed [14:0] left_speed;
	logic signed [14:0] right_speed;
	logic               led_on;
	logic        [1:0]  maneuver;

	modport source (output valid, left_speed, right_speed, led_on, maneuver,
		input ready);
	modport sink (input valid, left_speed, right_speed, led_on, maneuver,
		output ready);
endinterface

### hdl/wall_follow_cell_stepper_core.sv
// Wall-follow cell stepper: tick input register, maneuver control, command output register.
// A tick transfer yields its command through the input register and then the result register.
// Throughput: one tick per cycle unless output stalls; the control state settles in the single
// stage after the input register, so the next tick sees it on the following cycle.
// Output stalls back up into the input register only when both stages are full.
// Reset (arst_n low, asynchronous): state, held commands and LED cleared; registers to defaults.
module wall_follow_cell_stepper_core (
	input  logic        clk,
	input  logic        arst_n,
	wfcs_tick_if.sink   tick,
	wfcs_cmd_if.source  cmd,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	wfcs_pkg::cfg_t     cfg_q;
	logic [2:0]         reg_sel;
	logic               cfg_wr;

	logic               valid_s1;
	logic [11:0]        left_s1;
	logic [11:0]        front_s1;
	logic [11:0]        right_s1;
	logic signed [31:0] pos_s1;
	logic               advance;

	logic               moving_q;
	logic               fphase_q;
	logic signed [31:0] fp_q;
	logic signed [31:0] ft_q;
	logic signed [31:0] tp_q;
	logic signed [31:0] tt_q;
	logic [2:0]         pattern_q;
	logic signed [14:0] held_left_q;
	logic signed [14:0] held_right_q;
	logic               led_q;
	logic               out_valid_q;

	logic [2:0]         pattern_now;
	logic [2:0]         pattern;
	logic [1:0]         man;
	logic               is_fwd;
	logic               rightward;
	logic signed [31:0] fp_cmp;
	logic signed [31:0] ft_cmp;
	logic signed [31:0] tp_eff;
	logic signed [31:0] tt_eff;
	logic signed [31:0] turn_off;
	logic               fwd_go;
	logic               turning;
	logic               run_fwd;
	logic               drive_en;
	logic [1:0]         mode;
	logic signed [14:0] calc_left;
	logic signed [14:0] calc_right;
	logic signed [14:0] left_next;
	logic signed [14:0] right_next;
	logic               led_next;
	logic               moving_next;
	logic               fphase_next;
	logic signed [31:0] fp_next;
	logic signed [31:0] ft_next;
	logic signed [31:0] tp_next;
	logic signed [31:0] tt_next;

	// configuration port
	assign pready  = 1'b1;
	assign reg_sel = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_comb begin
		case (reg_sel)
			wfcs_pkg::REG_FRONT_THR:  prdata = {20'b0, cfg_q.front_threshold};
			wfcs_pkg::REG_LEFT_THR:   prdata = {20'b0, cfg_q.left_threshold};
			wfcs_pkg::REG_RIGHT_THR:  prdata = {20'b0, cfg_q.right_threshold};
			wfcs_pkg::REG_LEFT_SET:   prdata = {20'b0, cfg_q.left_setpoint};
			wfcs_pkg::REG_RIGHT_SET:  prdata = {20'b0, cfg_q.right_setpoint};
			wfcs_pkg::REG_LEFT_BASE:  prdata = {18'b0, cfg_q.left_base_speed};
			wfcs_pkg::REG_RIGHT_BASE: prdata = {18'b0, cfg_q.right_base_speed};
			wfcs_pkg::REG_GAIN:       prdata = {16'b0, cfg_q.steer_gain};
			default:                  prdata = 32'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.front_threshold  <= 12'd737;
			cfg_q.left_threshold   <= 12'd737;
			cfg_q.right_threshold  <= 12'd737;
			cfg_q.left_setpoint    <= 12'd475;
			cfg_q.right_setpoint   <= 12'd475;
			cfg_q.left_base_speed  <= 14'd4096;
			cfg_q.right_base_speed <= 14'd4096;
			cfg_q.steer_gain       <= 16'd655;
		end else if (cfg_wr) begin
			case (reg_sel)
				wfcs_pkg::REG_FRONT_THR:  cfg_q.front_threshold  <= pwdata[11:0];
				wfcs_pkg::REG_LEFT_THR:   cfg_q.left_threshold   <= pwdata[11:0];
				wfcs_pkg::REG_RIGHT_THR:  cfg_q.right_threshold  <= pwdata[11:0];
				wfcs_pkg::REG_LEFT_SET:   cfg_q.left_setpoint    <= pwdata[11:0];
				wfcs_pkg::REG_RIGHT_SET:  cfg_q.right_setpoint   <= pwdata[11:0];
				wfcs_pkg::REG_LEFT_BASE:  cfg_q.left_base_speed  <= pwdata[13:0];
				wfcs_pkg::REG_RIGHT_BASE: cfg_q.right_base_speed <= pwdata[13:0];
				wfcs_pkg::REG_GAIN:       cfg_q.steer_gain       <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// handshake
	assign advance    = valid_s1 && (!out_valid_q || cmd.ready);
	assign tick.ready = !valid_s1 || advance;
	assign cmd.valid  = out_valid_q;

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			left_s1  <= tick.left_distance;
			front_s1 <= tick.front_distance;
			right_s1 <= tick.right_distance;
			pos_s1   <= tick.wheel_position;
		end
	end

	// maneuver control
	assign pattern_now = {right_s1 < cfg_q.right_threshold, left_s1 < cfg_q.left_threshold,
		front_s1 < cfg_q.front_threshold};
	assign pattern   = moving_q ? pattern_q : pattern_now;
	assign man       = wfcs_pkg::maneuver_of(pattern);
	assign is_fwd    = man == wfcs_pkg::MAN_FORWARD;
	assign rightward = man == wfcs_pkg::MAN_RIGHT;

	assign fp_cmp = (is_fwd && !moving_q) ? pos_s1 : fp_q;
	assign ft_cmp = (is_fwd && !moving_q) ? pos_s1 + wfcs_pkg::CELL_COUNTS : ft_q;
	assign fwd_go = fp_cmp <= ft_cmp;

	assign turn_off = (man == wfcs_pkg::MAN_UTURN) ? -wfcs_pkg::UTURN_COUNTS :
		(rightward ? wfcs_pkg::PIVOT_COUNTS : -wfcs_pkg::PIVOT_COUNTS);
	assign tp_eff  = moving_q ? tp_q : pos_s1;
	assign tt_eff  = moving_q ? tt_q : pos_s1 + turn_off;
	assign turning = !is_fwd && (rightward ? (tp_eff <= tt_eff) : (tp_eff >= tt_eff));

	assign run_fwd  = is_fwd || (!turning && fphase_q);
	assign drive_en = turning || run_fwd;
	assign mode     = turning ? (rightward ? wfcs_pkg::DRV_PIVOT_R : wfcs_pkg::DRV_PIVOT_L) :
		(fwd_go ? wfcs_pkg::DRV_TRIM : wfcs_pkg::DRV_FIFTH);

	wfcs_speed_calc u_speed (
		.cfg           (cfg_q),
		.left_distance (left_s1),
		.right_distance(right_s1),
		.mode          (mode),
		.left_speed    (calc_left),
		.right_speed   (calc_right)
	);

	always_comb begin
		moving_next = moving_q;
		fphase_next = fphase_q;
		fp_next     = fp_q;
		ft_next     = ft_q;
		tp_next     = tp_q;
		tt_next     = tt_q;
		led_next    = led_q;
		if (!is_fwd) begin
			moving_next = 1'b1;
			tp_next     = turning ? pos_s1 : tp_eff;
			tt_next     = tt_eff;
			if (!turning && !fphase_q) begin
				fp_next     = pos_s1;
				ft_next     = pos_s1 + wfcs_pkg::CELL_COUNTS;
				fphase_next = 1'b1;
			end
		end
		if (run_fwd) begin
			led_next    = !fwd_go;
			moving_next = fwd_go;
			fp_next     = fwd_go ? pos_s1 : fp_cmp;
			ft_next     = ft_cmp;
			if (!fwd_go) begin
				fphase_next = 1'b0;
			end
		end
	end

	assign left_next  = drive_en ? calc_left : held_left_q;
	assign right_next = drive_en ? calc_right : held_right_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
			moving_q     <= 1'b0;
			fphase_q     <= 1'b0;
			fp_q         <= '0;
			ft_q         <= '0;
			tp_q         <= '0;
			tt_q         <= '0;
			pattern_q    <= '0;
			held_left_q  <= '0;
			held_right_q <= '0;
			led_q        <= 1'b0;
		end else begin
			if (tick.ready) begin
				valid_s1 <= tick.valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (cmd.ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				moving_q     <= moving_next;
				fphase_q     <= fphase_next;
				fp_q         <= fp_next;
				ft_q         <= ft_next;
				tp_q         <= tp_next;
				tt_q         <= tt_next;
				pattern_q    <= pattern;
				held_left_q  <= left_next;
				held_right_q <= right_next;
				led_q        <= led_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cmd.left_speed  <= left_next;
			cmd.right_speed <= right_next;
			cmd.led_on      <= led_next;
			cmd.maneuver    <= man;
		end
	end

endmodule

### hdl/wfcs_speed_calc.sv
// Wheel speed computation: wall trim, fifth cruise, pivot half speeds, clamp.
module wfcs_speed_calc (
	input  wfcs_pkg::cfg_t     cfg,
	input  logic [11:0]        left_distance,
	input  logic [11:0]        right_distance,
	input  logic [1:0]         mode,
	output logic signed [14:0] left_speed,
	output logic signed [14:0] right_speed
);
	logic               use_left;
	logic               use_right;
	logic [11:0]        reading;
	logic [11:0]        setpoint;
	logic signed [12:0] err;
	logic signed [16:0] gain_s;
	logic signed [29:0] prod;
	logic signed [29:0] prod_neg;
	logic [28:0]        mag;
	logic [29:0]        mag_rnd;
	logic signed [24:0] d;
	logic signed [24:0] dl;
	logic signed [24:0] lb;
	logic signed [24:0] rb;
	logic [14:0]        lf_sum;
	logic [14:0]        rf_sum;
	logic [30:0]        lf_prod;
	logic [30:0]        rf_prod;
	logic [14:0]        lh_sum;
	logic [14:0]        rh_sum;
	logic signed [24:0] lfifth;
	logic signed [24:0] rfifth;
	logic signed [24:0] lhalf;
	logic signed [24:0] rhalf;
	logic signed [24:0] left_raw;
	logic signed [24:0] right_raw;

	assign use_left  = left_distance < cfg.left_threshold;
	assign use_right = !use_left && (right_distance < cfg.right_threshold);
	assign reading   = use_left ? left_distance : right_distance;
	assign setpoint  = use_left ? cfg.left_setpoint : cfg.right_setpoint;

	assign err      = $signed({1'b0, reading}) - $signed({1'b0, setpoint});
	assign gain_s   = $signed({1'b0, cfg.steer_gain});
	assign prod     = err * gain_s;
	assign prod_neg = -prod;
	assign mag      = prod[29] ? prod_neg[28:0] : prod[28:0];
	assign mag_rnd  = {1'b0, mag} + 30'd32;
	assign d        = prod[29] ? -$signed({1'b0, mag_rnd[29:6]}) : $signed({1'b0, mag_rnd[29:6]});
	assign dl       = use_left ? -d : (use_right ? d : 25'sd0);

	assign lb = $signed({11'b0, cfg.left_base_speed});
	assign rb = $signed({11'b0, cfg.right_base_speed});

	assign lf_sum  = {1'b0, cfg.left_base_speed} + 15'd2;
	assign rf_sum  = {1'b0, cfg.right_base_speed} + 15'd2;
	assign lf_prod = {16'b0, lf_sum} * {15'b0, wfcs_pkg::FIFTH_RECIP};
	assign rf_prod = {16'b0, rf_sum} * {15'b0, wfcs_pkg::FIFTH_RECIP};
	assign lfifth  = $signed({12'b0, lf_prod[30:wfcs_pkg::FIFTH_SHIFT]});
	assign rfifth  = $signed({12'b0, rf_prod[30:wfcs_pkg::FIFTH_SHIFT]});

	assign lh_sum = {1'b0, cfg.left_base_speed} + 15'd1;
	assign rh_sum = {1'b0, cfg.right_base_speed} + 15'd1;
	assign lhalf  = $signed({11'b0, lh_sum[14:1]});
	assign rhalf  = $signed({11'b0, rh_sum[14:1]});

	always_comb begin
		case (mode)
			wfcs_pkg::DRV_TRIM: begin
				left_raw  = lb + dl;
				right_raw = rb - dl;
			end
			wfcs_pkg::DRV_FIFTH: begin
				left_raw  = lfifth;
				right_raw = rfifth;
			end
			wfcs_pkg::DRV_PIVOT_L: begin
				left_raw  = -lhalf;
				right_raw = rhalf;
			end
			default: begin
				left_raw  = lhalf;
				right_raw = -rhalf;
			end
		endcase
	end

	assign left_speed  = wfcs_pkg::clamp_speed(left_raw);
	assign right_speed = wfcs_pkg::clamp_speed(right_raw);

endmodule

### verif/tb.sv
// Testbench for wall_follow_cell_stepper_core: random ticks against a behavioral scoreboard.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic signed [31:0] CELL_STEPS  = 32'sd15;
	localparam logic signed [31:0] PIVOT_STEPS = 32'sd7;
	localparam logic signed [31:0] UTURN_STEPS = 32'sd14;
	localparam longint WHEEL_MAX = 10240;
	localparam int PHASES = 9;
	localparam int PHASE_TICKS = 105;
	localparam int HOLD_CYCLES = 300;

	localparam wfcs_pkg::cfg_t RESET_CFG = '{12'd737, 12'd737, 12'd737, 12'd475, 12'd475,
		14'd4096, 14'd4096, 16'd655};

	typedef struct {
		logic        [11:0] left;
		logic        [11:0] front;
		logic        [11:0] right;
		logic signed [31:0] pos;
	} tick_t;

	typedef struct {
		logic signed [14:0] left_speed;
		logic signed [14:0] right_speed;
		logic               led_on;
		logic        [1:0]  maneuver;
	} wheel_cmd_t;

	class wheel_cmd_scoreboard;
		wfcs_pkg::cfg_t     cfg;
		bit                 moving;
		bit                 fwd_phase;
		bit                 led;
		logic signed [31:0] fwd_pos;
		logic signed [31:0] fwd_tgt;
		logic signed [31:0] turn_pos;
		logic signed [31:0] turn_tgt;
		logic        [2:0]  walls;
		logic signed [14:0] left_cmd;
		logic signed [14:0] right_cmd;
		wheel_cmd_t         expected_cmds[$];
		int                 errors;

		function new();
			cfg = RESET_CFG;
			moving = 0;
			fwd_phase = 0;
			led = 0;
			fwd_pos = '0;
			fwd_tgt = '0;
			turn_pos = '0;
			turn_tgt = '0;
			walls = '0;
			left_cmd = '0;
			right_cmd = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				wfcs_pkg::REG_FRONT_THR:  cfg.front_threshold = val[11:0];
				wfcs_pkg::REG_LEFT_THR:   cfg.left_threshold = val[11:0];
				wfcs_pkg::REG_RIGHT_THR:  cfg.right_threshold = val[11:0];
				wfcs_pkg::REG_LEFT_SET:   cfg.left_setpoint = val[11:0];
				wfcs_pkg::REG_RIGHT_SET:  cfg.right_setpoint = val[11:0];
				wfcs_pkg::REG_LEFT_BASE:  cfg.left_base_speed = val[13:0];
				wfcs_pkg::REG_RIGHT_BASE: cfg.right_base_speed = val[13:0];
				wfcs_pkg::REG_GAIN:       cfg.steer_gain = val[15:0];
				default: ;
			endcase
		endfunction

		function logic [1:0] maneuver_for(logic [2:0] w);
			case (w)
				3'd1, 3'd4, 3'd5: return wfcs_pkg::MAN_LEFT;
				3'd3:             return wfcs_pkg::MAN_RIGHT;
				3'd7:             return wfcs_pkg::MAN_UTURN;
				default:          return wfcs_pkg::MAN_FORWARD;
			endcase
		endfunction

		function logic signed [14:0] sat(longint v);
			if (v > WHEEL_MAX) return 15'(WHEEL_MAX);
			if (v < -WHEEL_MAX) return 15'(-WHEEL_MAX);
			return 15'(v);
		endfunction

		function void set_wheels(longint l, longint r);
			left_cmd = sat(l);
			right_cmd = sat(r);
		endfunction

		// proportional trim, rounded to nearest with ties away from zero
		function longint steer(logic [11:0] reading, logic [11:0] setpoint);
			longint p;
			longint mag;
			longint q;
			p = (longint'(reading) - longint'(setpoint)) * longint'(cfg.steer_gain);
			mag = (p < 0) ? -p : p;
			q = (mag + 32) >>> 6;
			return (p < 0) ? -q : q;
		endfunction

		function void follow(tick_t t);
			longint lb;
			longint rb;
			longint d;
			lb = longint'(cfg.left_base_speed);
			rb = longint'(cfg.right_base_speed);
			if (t.left < cfg.left_threshold) begin
				d = steer(t.left, cfg.left_setpoint);
				set_wheels(lb - d, rb + d);
			end else if (t.right < cfg.right_threshold) begin
				d = steer(t.right, cfg.right_setpoint);
				set_wheels(lb + d, rb - d);
			end else begin
				set_wheels(lb, rb);
			end
		endfunction

		function void forward_step(tick_t t);
			led = 0;
			if (!moving) begin
				fwd_pos = t.pos;
				fwd_tgt = t.pos + CELL_STEPS;
				moving = 1;
			end
			if (fwd_pos <= fwd_tgt) begin
				fwd_pos = t.pos;
				follow(t);
			end else begin
				moving = 0;
				fwd_phase = 0;
				set_wheels((longint'(cfg.left_base_speed) + 2) / 5,
					(longint'(cfg.right_base_speed) + 2) / 5);
				led = 1;
			end
		endfunction

		function void pivot_step(tick_t t, bit rightward, logic signed [31:0] counts);
			bit     turning;
			longint hl;
			longint hr;
			hl = (longint'(cfg.left_base_speed) + 1) >>> 1;
			hr = (longint'(cfg.right_base_speed) + 1) >>> 1;
			if (!moving) begin
				turn_pos = t.pos;
				turn_tgt = rightward ? t.pos + counts : t.pos - counts;
				moving = 1;
			end
			turning = rightward ? (turn_pos <= turn_tgt) : (turn_pos >= turn_tgt);
			if (turning) begin
				turn_pos = t.pos;
				if (rightward) set_wheels(hl, -hr);
				else set_wheels(-hl, hr);
			end else if (!fwd_phase) begin
				fwd_pos = t.pos;
				fwd_tgt = t.pos + CELL_STEPS;
				fwd_phase = 1;
			end else begin
				forward_step(t);
			end
		endfunction

		function void note_tick(tick_t t);
			wheel_cmd_t c;
			logic [1:0] man;
			if (!moving)
				walls = {t.right < cfg.right_threshold, t.left < cfg.left_threshold,
					t.front < cfg.front_threshold};
			man = maneuver_for(walls);
			case (man)
				wfcs_pkg::MAN_FORWARD: forward_step(t);
				wfcs_pkg::MAN_LEFT:    pivot_step(t, 1'b0, PIVOT_STEPS);
				wfcs_pkg::MAN_RIGHT:   pivot_step(t, 1'b1, PIVOT_STEPS);
				default:               pivot_step(t, 1'b0, UTURN_STEPS);
			endcase
			c.left_speed = left_cmd;
			c.right_speed = right_cmd;
			c.led_on = led;
			c.maneuver = man;
			expected_cmds.push_back(c);
		endfunction

		task report(string msg);
			$display("[tb] mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_cmd(wheel_cmd_t got);
			wheel_cmd_t want;
			if (expected_cmds.size() == 0) begin
				report("command transfer with nothing pending");
				return;
			end
			want = expected_cmds.pop_front();
			if (got.left_speed !== want.left_speed)
				report($sformatf("left_speed got %0d want %0d", got.left_speed,
					want.left_speed));
			if (got.right_speed !== want.right_speed)
				report($sformatf("right_speed got %0d want %0d", got.right_speed,
					want.right_speed));
			if (got.led_on !== want.led_on)
				report($sformatf("led_on got %0b want %0b", got.led_on, want.led_on));
			if (got.maneuver !== want.maneuver)
				report($sformatf("maneuver got %0d want %0d", got.maneuver, want.maneuver));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	wfcs_tick_if tick_ch();
	wfcs_cmd_if  cmd_ch();

	wheel_cmd_scoreboard sb = new();

	logic signed [31:0] enc;
	bit tx_burst;
	bit rx_burst;
	bit hold_cmd;

	wall_follow_cell_stepper_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (tick_ch),
		.cmd     (cmd_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (tick_ch.valid && tick_ch.ready)
				sb.note_tick(tick_t'{tick_ch.left_distance, tick_ch.front_distance,
					tick_ch.right_distance, tick_ch.wheel_position});
			if (cmd_ch.valid && cmd_ch.ready)
				sb.check_cmd(wheel_cmd_t'{cmd_ch.left_speed, cmd_ch.right_speed,
					cmd_ch.led_on, cmd_ch.maneuver});
		end
	end

	function automatic tick_t mk(int l, int f, int r, logic signed [31:0] p);
		tick_t t;
		t.left = l[11:0];
		t.front = f[11:0];
		t.right = r[11:0];
		t.pos = p;
		return t;
	endfunction

	function automatic logic [11:0] pick_reading(logic [11:0] thr, logic [11:0] sp);
		int v;
		case ($urandom_range(0, 9))
			0: v = 0;
			1: v = 4095;
			2, 3: v = (thr == 0) ? 0 : int'($urandom_range(0, thr - 1));
			4, 5: v = int'($urandom_range(thr, 4095));
			6: v = int'(thr) + int'($urandom_range(0, 2)) - 1;
			7: v = int'(sp) + int'($urandom_range(0, 64)) - 32;
			default: v = int'($urandom_range(0, 4095));
		endcase
		if (v < 0) v = 0;
		if (v > 4095) v = 4095;
		return v[11:0];
	endfunction

	// encoder mostly walks the way the current move needs, with jumps as noise
	function automatic tick_t next_tick();
		tick_t      t;
		int         r;
		logic [1:0] man;
		t.left = pick_reading(sb.cfg.left_threshold, sb.cfg.left_setpoint);
		t.front = pick_reading(sb.cfg.front_threshold, sb.cfg.front_threshold);
		t.right = pick_reading(sb.cfg.right_threshold, sb.cfg.right_setpoint);
		man = sb.maneuver_for(sb.walls);
		r = $urandom_range(0, 99);
		if (r < 3)
			enc = $urandom;
		else if (r < 5)
			enc = 32'sh7FFF_FFF0 + $urandom_range(0, 15);
		else if (r < 14)
			enc = enc + $urandom_range(0, 80) - 40;
		else if (sb.moving && !sb.fwd_phase &&
			(man == wfcs_pkg::MAN_LEFT || man == wfcs_pkg::MAN_UTURN))
			enc = enc - $urandom_range(0, 3);
		else
			enc = enc + $urandom_range(0, 3);
		t.pos = enc;
		return t;
	endfunction

	function automatic wfcs_pkg::cfg_t pick_config(int p);
		wfcs_pkg::cfg_t c;
		case (p)
			0: c = '{12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095,
				14'd16383, 14'd16383, 16'hFFFF};
			1: c = '0;
			2: c = RESET_CFG;
			3: begin
				c = '{12'd2048, 12'd2048, 12'd2048, 12'd0, 12'd0,
					14'd10240, 14'd10240, 16'hFFFF};
				c.left_setpoint = 12'($urandom_range(0, 4095));
				c.right_setpoint = 12'($urandom_range(0, 4095));
			end
			default: begin
				c.front_threshold = 12'($urandom_range(200, 3900));
				c.left_threshold = 12'($urandom_range(200, 3900));
				c.right_threshold = 12'($urandom_range(200, 3900));
				c.left_setpoint = 12'($urandom_range(0, 4095));
				c.right_setpoint = 12'($urandom_range(0, 4095));
				c.left_base_speed = 14'($urandom_range(0, 16383));
				c.right_base_speed = 14'($urandom_range(0, 16383));
				c.steer_gain = 16'($urandom_range(0, 65535));
			end
		endcase
		return c;
	endfunction

	task automatic apb_access(bit wr, logic [2:0] idx, logic [31:0] val,
		output logic [31:0] rd);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rd = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		logic [31:0] rd;
		apb_access(1'b1, idx, val, rd);
		sb.set_reg(idx, val);
		apb_access(1'b0, idx, '0, rd);
		if (rd !== val)
			sb.report($sformatf("register %0d reads %0h, written %0h", idx, rd, val));
	endtask

	task automatic load_config(wfcs_pkg::cfg_t c);
		write_reg(wfcs_pkg::REG_FRONT_THR, 32'(c.front_threshold));
		write_reg(wfcs_pkg::REG_LEFT_THR, 32'(c.left_threshold));
		write_reg(wfcs_pkg::REG_RIGHT_THR, 32'(c.right_threshold));
		write_reg(wfcs_pkg::REG_LEFT_SET, 32'(c.left_setpoint));
		write_reg(wfcs_pkg::REG_RIGHT_SET, 32'(c.right_setpoint));
		write_reg(wfcs_pkg::REG_LEFT_BASE, 32'(c.left_base_speed));
		write_reg(wfcs_pkg::REG_RIGHT_BASE, 32'(c.right_base_speed));
		write_reg(wfcs_pkg::REG_GAIN, 32'(c.steer_gain));
	endtask

	// entered at a falling edge, returns at the falling edge after the transfer
	task automatic send_tick(tick_t t);
		int gap;
		if ($urandom_range(0, 29) == 0) tx_burst = !tx_burst;
		gap = tx_burst ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			tick_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.left_distance <= t.left;
		tick_ch.front_distance <= t.front;
		tick_ch.right_distance <= t.right;
		tick_ch.wheel_position <= t.pos;
		@(posedge clk);
		while (!tick_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		tick_ch.valid <= 1'b0;
		while (sb.expected_cmds.size() != 0) @(negedge clk);
	endtask

	initial begin
		int wait_n;
		cmd_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
			wait_n = rx_burst ? 0 : $urandom_range(0, 14);
			if (hold_cmd) begin
				hold_cmd = 1'b0;
				wait_n = HOLD_CYCLES;
			end
			if (wait_n > 0) begin
				cmd_ch.ready <= 1'b0;
				repeat (wait_n) @(negedge clk);
			end
			cmd_ch.ready <= 1'b1;
			@(posedge clk);
			while (!cmd_ch.valid) @(posedge clk);
			@(negedge clk);
		end
	end

	initial begin
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		tick_ch.valid <= 1'b0;
		tick_ch.left_distance <= '0;
		tick_ch.front_distance <= '0;
		tick_ch.right_distance <= '0;
		tick_ch.wheel_position <= '0;
		enc = '0;
		tx_burst = 0;
		rx_burst = 0;
		hold_cmd = 0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: every move, both trim ties, threshold edges, encoder wrap
		send_tick(mk(4095, 4095, 4095, 32'sd0));
		send_tick(mk(507, 4095, 4095, 32'sd8));
		send_tick(mk(443, 4095, 4095, 32'sd15));
		send_tick(mk(4095, 4095, 0, 32'sd16));
		send_tick(mk(737, 4095, 736, 32'sd20));
		send_tick(mk(737, 0, 737, 32'sd100));
		send_tick(mk(0, 0, 0, 32'sd95));
		send_tick(mk(0, 0, 0, 32'sd92));
		send_tick(mk(0, 0, 0, 32'sd90));
		send_tick(mk(4095, 4095, 4095, 32'sd106));
		send_tick(mk(4095, 4095, 4095, 32'sd110));
		send_tick(mk(0, 0, 4095, 32'sh7FFF_FFFC));
		send_tick(mk(4095, 4095, 4095, 32'sh7FFF_FFFE));
		send_tick(mk(0, 0, 0, 32'sh8000_0000));
		send_tick(mk(4095, 4095, 4095, 32'sh8000_0010));
		send_tick(mk(4095, 4095, 4095, 32'sh8000_0012));
		send_tick(mk(4095, 0, 0, 32'sd50));
		send_tick(mk(4095, 4095, 4095, 32'sd0));
		send_tick(mk(4095, 4095, 4095, 32'sd0));
		send_tick(mk(4095, 4095, 4095, 32'sd40));
		send_tick(mk(4095, 4095, 4095, 32'sd41));
		send_tick(mk(4095, 4095, 0, 32'sd0));
		send_tick(mk(0, 4095, 4095, -32'sd100));
		drain();

		for (int p = 0; p < PHASES; p++) begin
			load_config(pick_config(p));
			for (int i = 0; i < PHASE_TICKS; i++) begin
				if ((p == 3 || p == 6) && i == 40) hold_cmd = 1'b1;
				send_tick(next_tick());
			end
			drain();
		end

		repeat (4) @(negedge clk);
		if (sb.errors == 0) begin
			$display("[wall_follow_cell_stepper_core] OK");
		end else begin
			$display("[wall_follow_cell_stepper_core] ERROR");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("[wall_follow_cell_stepper_core] ERROR");
		$finish;
	end

endmodule
